// ----- sv/sps_pkg.sv -----
package sps_pkg;

    localparam int DUR_W   = 24;
    localparam int LEVEL_W = 16;
    localparam int FRAC_W  = 16;
    localparam int ENTRY_W = DUR_W + 2 * LEVEL_W + 1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CHK,
        ST_POST,
        ST_DIV,
        ST_MAP,
        ST_MUL,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DUR_W-1:0] num;
        logic [DUR_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [FRAC_W-1:0] quo;
    } t_div_rsp;

endpackage

// ----- sv/sps_ram.sv -----
module sps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/sps_div.sv -----
module sps_div
    import sps_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DUR_W-1:0]          r_rem, n_rem;
    logic [DUR_W-1:0]          r_den;
    logic [FRAC_W-1:0]         r_quo, n_quo;
    logic [$clog2(FRAC_W)-1:0] r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [DUR_W:0]            rem2;

    always_comb begin
        rem2 = {r_rem, 1'b0};
        if (rem2 >= {1'b0, r_den}) begin
            n_rem = DUR_W'(rem2 - {1'b0, r_den});
            n_quo = {r_quo[FRAC_W-2:0], 1'b1};
        end else begin
            n_rem = rem2[DUR_W-1:0];
            n_quo = {r_quo[FRAC_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_den <= i_req.den;
            r_quo <= '0;
            r_cnt <= '1;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// ----- sv/stage_profile_setpoint_top.sv -----
// Staged setpoint generator. A load beat writes one stage slot and returns the
// new total duration; a query beat returns the interpolated target for an
// elapsed time. Each beat yields one result. The stage table sits in a RAM with
// a registered read port and is walked stage by stage through a read and a check
// state for each stage in use; a query that falls inside a stage then runs the
// bit-serial fraction divider. A new beat is taken once the previous one has
// left the sequencer, while its result may still wait in the output register.
module stage_profile_setpoint_top
    import sps_pkg::*;
#(
    parameter int MAX_STAGES = 8,
    parameter int SMOOTH_TABLE_BITS = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [3:0]                i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_command,
    input  logic [2:0]                i_stage_slot,
    input  logic [23:0]               i_stage_duration,
    input  logic signed [15:0]        i_start_level,
    input  logic signed [15:0]        i_end_level,
    input  logic                      i_smooth_shape,
    input  logic [31:0]               i_elapsed_time,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [15:0]        o_target_level,
    output logic [2:0]                o_current_stage,
    output logic                      o_past_end,
    output logic [26:0]               o_total_time
);

    localparam int A_W      = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int K_W      = $clog2(MAX_STAGES + 1);
    localparam int ACC_W    = DUR_W + K_W;
    localparam int ROM_SIZE = 1 << SMOOTH_TABLE_BITS;
    localparam real PI      = 3.141592653589793;

    typedef logic [FRAC_W-1:0] t_rom [ROM_SIZE];

    function automatic t_rom build_rom();
        t_rom r;
        real  v;
        for (int i = 0; i < ROM_SIZE; i++) begin
            v = 32768.0 * (1.0 - $cos(PI * i / ROM_SIZE)) + 0.5;
            if (v >= 65535.0) begin
                r[i] = '1;
            end else begin
                r[i] = FRAC_W'($rtoi(v));
            end
        end
        return r;
    endfunction

    localparam t_rom ROM = build_rom();

    t_state r_state, n_state;

    logic [3:0]               r_count;
    logic                     r_query;
    logic [31:0]              r_time;
    logic [K_W-1:0]           r_n;
    logic [K_W-1:0]           r_k;
    logic [K_W-1:0]           r_stage;
    logic [ACC_W-1:0]         r_acc;
    logic                     r_found;
    logic [DUR_W-1:0]         r_dur;
    logic [DUR_W-1:0]         r_off;
    logic signed [15:0]       r_start;
    logic signed [15:0]       r_end;
    logic signed [15:0]       r_last_end;
    logic                     r_smooth;
    logic [FRAC_W-1:0]        r_f;
    logic signed [33:0]       r_prod;

    logic                     r_out_valid;
    logic signed [15:0]       r_out_target;
    logic [2:0]               r_out_stage;
    logic                     r_out_past;
    logic [26:0]              r_out_total;

    logic [ENTRY_W-1:0]       rdata;
    logic [ENTRY_W-1:0]       wdata;
    logic                     we;
    logic                     accept;
    logic [DUR_W-1:0]         e_dur;
    logic signed [15:0]       e_start;
    logic signed [15:0]       e_end;
    logic                     e_smooth;
    logic [ACC_W-1:0]         sum;
    logic                     hit;
    logic [K_W-1:0]           n_use;
    logic signed [16:0]       diff;
    logic signed [15:0]       target;
    logic [K_W+2:0]           stage_ext;
    logic [ACC_W+26:0]        total_ext;
    t_div_req                 div_req;
    t_div_rsp                 div_rsp;

    assign accept = i_in_valid && !o_in_stall;
    assign we     = accept && (i_command == CMD_LOAD) && (int'(i_stage_slot) < MAX_STAGES);
    assign wdata  = {i_stage_duration, i_start_level, i_end_level, i_smooth_shape};
    assign n_use  = (int'(r_count) > MAX_STAGES) ? K_W'(MAX_STAGES) : K_W'(r_count);

    sps_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_STAGES),
        .ADDR_W(A_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(A_W'(i_stage_slot)),
        .i_wdata(wdata),
        .i_raddr(r_k[A_W-1:0]),
        .o_rdata(rdata)
    );

    assign {e_dur, e_start, e_end, e_smooth} = rdata;
    assign sum = r_acc + ACC_W'(e_dur);
    assign hit = r_query && !r_found && ({1'b0, r_time} < 33'(sum));

    assign div_req.start = (r_state == ST_POST) && r_found;
    assign div_req.num   = r_off;
    assign div_req.den   = r_dur;

    sps_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    assign diff = 17'(r_end) - 17'(r_start);

    always_comb begin
        if (!r_query) begin
            target = '0;
        end else if (r_found) begin
            target = r_start + $signed(r_prod[31:16]);
        end else if (r_n != '0) begin
            target = r_last_end;
        end else begin
            target = '0;
        end
    end

    assign stage_ext = {3'b000, r_stage};
    assign total_ext = {27'd0, r_acc};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (n_use == '0) ? ST_POST : ST_RD;
                end
            end
            ST_RD:   n_state = ST_CHK;
            ST_CHK:  n_state = (r_k + 1'b1 == r_n) ? ST_POST : ST_RD;
            ST_POST: n_state = r_found ? ST_DIV : ST_FIN;
            ST_DIV:  n_state = div_rsp.done ? ST_MAP : ST_DIV;
            ST_MAP:  n_state = ST_MUL;
            ST_MUL:  n_state = ST_FIN;
            ST_FIN:  n_state = (!r_out_valid || !i_out_stall) ? ST_IDLE : ST_FIN;
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if (accept) begin
                r_found <= 1'b0;
            end else if ((r_state == ST_CHK) && hit) begin
                r_found <= 1'b1;
            end
            if ((r_state == ST_FIN) && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_query <= (i_command == CMD_QUERY);
            r_time  <= i_elapsed_time;
            r_n     <= n_use;
            r_k     <= '0;
            r_stage <= '0;
            r_acc   <= '0;
        end
        if (r_state == ST_CHK) begin
            r_acc      <= sum;
            r_last_end <= e_end;
            r_k        <= r_k + 1'b1;
            if (!r_found) begin
                r_stage <= r_k;
            end
            if (hit) begin
                r_dur    <= e_dur;
                r_off    <= r_time[DUR_W-1:0] - r_acc[DUR_W-1:0];
                r_start  <= e_start;
                r_end    <= e_end;
                r_smooth <= e_smooth;
            end
        end
        if (r_state == ST_MAP) begin
            r_f <= r_smooth ? ROM[div_rsp.quo[FRAC_W-1 -: SMOOTH_TABLE_BITS]] : div_rsp.quo;
        end
        if (r_state == ST_MUL) begin
            r_prod <= $signed({1'b0, r_f}) * diff;
        end
        if ((r_state == ST_FIN) && (!r_out_valid || !i_out_stall)) begin
            r_out_target <= target;
            r_out_stage  <= r_query ? stage_ext[2:0] : 3'd0;
            r_out_past   <= r_query && !r_found;
            r_out_total  <= total_ext[26:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_target_level  = r_out_target;
    assign o_current_stage = r_out_stage;
    assign o_past_end      = r_out_past;
    assign o_total_time    = r_out_total;

    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_stage < r_n))
        else $error("active stage beyond stages in use");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_DIV))
        else $error("divider finished outside divide phase");

    a_map_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAP) |-> (r_found && r_query))
        else $error("interpolation without an active stage");

    a_fin_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FIN) && !r_out_valid) |=> r_out_valid)
        else $error("finished beat not presented");

endmodule

// ----- tb/stage_profile_setpoint_checker.sv -----
`timescale 1ns / 100ps

module stage_profile_setpoint_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_command,
    input  logic [2:0]         i_stage_slot,
    input  logic [23:0]        i_stage_duration,
    input  logic signed [15:0] i_start_level,
    input  logic signed [15:0] i_end_level,
    input  logic               i_smooth_shape,
    input  logic [31:0]        i_elapsed_time,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [15:0] i_target_level,
    input  logic [2:0]         i_current_stage,
    input  logic               i_past_end,
    input  logic [26:0]        i_total_time,
    output int                 o_errors,
    output int                 o_pending
);
    import sps_pkg::*;

    localparam int NUM_SLOTS = 8;

    typedef struct {
        logic signed [15:0] target;
        logic [2:0]         stage;
        logic               past;
        logic [26:0]        total;
    } t_setpoint;

    t_setpoint          setpoint_q[$];
    logic [3:0]         stage_count;
    logic [23:0]        dur_tab[NUM_SLOTS];
    logic signed [15:0] start_tab[NUM_SLOTS];
    logic signed [15:0] end_tab[NUM_SLOTS];
    logic               smooth_tab[NUM_SLOTS];
    int unsigned        cosine_rom[1024];

    initial begin
        real v;
        o_errors = 0;
        stage_count = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            dur_tab[i] = '0;
            start_tab[i] = '0;
            end_tab[i] = '0;
            smooth_tab[i] = 1'b0;
        end
        for (int i = 0; i < 1024; i++) begin
            v = 32768.0 * (1.0 - $cos(3.14159265358979323846 * i / 1024.0));
            v = $floor(v + 0.5);
            cosine_rom[i] = (v > 65535.0) ? 65535 : int'(v);
        end
    end

    assign o_pending = setpoint_q.size();

    function automatic logic [63:0] sum_durations(logic [3:0] cnt);
        logic [63:0] s;
        int n;
        s = '0;
        n = (cnt > NUM_SLOTS) ? NUM_SLOTS : cnt;
        for (int i = 0; i < n; i++) s += dur_tab[i];
        return s;
    endfunction

    function automatic t_setpoint query_setpoint(logic [31:0] t);
        t_setpoint r;
        logic [63:0] acc, offset, frac;
        longint p;
        int n;
        bit found;
        r.target = '0;
        r.stage = '0;
        r.past = 1'b0;
        r.total = 27'(sum_durations(stage_count));
        acc = '0;
        found = 0;
        n = (stage_count > NUM_SLOTS) ? NUM_SLOTS : stage_count;
        for (int i = 0; i < n; i++) begin
            if (!found && {32'd0, t} < acc + dur_tab[i]) begin
                offset = t - acc;
                frac = (offset << 16) / dur_tab[i];
                if (smooth_tab[i]) frac = cosine_rom[frac >> 6];
                p = longint'(frac) * longint'(int'(end_tab[i]) - int'(start_tab[i]));
                r.target = 16'(longint'(start_tab[i]) + (p >>> 16));
                r.stage = 3'(i);
                found = 1;
            end
            acc += dur_tab[i];
        end
        if (!found) begin
            r.past = 1'b1;
            if (n > 0) begin
                r.target = end_tab[n-1];
                r.stage = 3'(n - 1);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_setpoint r, e;
        if (i_rst_n) begin
            if (i_cfg_we) stage_count <= i_cfg_wdata;
            if (i_in_valid && !i_in_stall) begin
                if (i_command == CMD_LOAD) begin
                    dur_tab[i_stage_slot] = i_stage_duration;
                    start_tab[i_stage_slot] = i_start_level;
                    end_tab[i_stage_slot] = i_end_level;
                    smooth_tab[i_stage_slot] = i_smooth_shape;
                    r.target = '0;
                    r.stage = '0;
                    r.past = 1'b0;
                    r.total = 27'(sum_durations(stage_count));
                end else begin
                    r = query_setpoint(i_elapsed_time);
                end
                setpoint_q.push_back(r);
            end
            if (i_out_valid && !i_out_stall) begin
                if (setpoint_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $realtime);
                    o_errors++;
                end else begin
                    e = setpoint_q.pop_front();
                    if (i_target_level !== e.target)
                        report_mismatch("target_level", i_target_level, e.target);
                    if (i_current_stage !== e.stage)
                        report_mismatch("current_stage", i_current_stage, e.stage);
                    if (i_past_end !== e.past)
                        report_mismatch("past_end", i_past_end, e.past);
                    if (i_total_time !== e.total)
                        report_mismatch("total_time", i_total_time, e.total);
                end
            end
        end
    end

endmodule

// ----- tb/stage_profile_setpoint_top_tb.sv -----
`timescale 1ns / 100ps

module stage_profile_setpoint_top_tb;
    import sps_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [3:0]         cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               command = CMD_QUERY;
    logic [2:0]         stage_slot = '0;
    logic [23:0]        stage_duration = '0;
    logic signed [15:0] start_level = '0;
    logic signed [15:0] end_level = '0;
    logic               smooth_shape = 1'b0;
    logic [31:0]        elapsed_time = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] target_level;
    logic [2:0]         current_stage;
    logic               past_end;
    logic [26:0]        total_time;
    int                 errors, pending;
    int                 idle_cycles = 0;
    int                 n_loads = 0, n_queries = 0, n_configs = 0;
    bit                 sender_idles = 1, receiver_idles = 1, long_hold = 0;

    always #5 clk = ~clk;

    stage_profile_setpoint_top uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_command(command), .i_stage_slot(stage_slot),
        .i_stage_duration(stage_duration), .i_start_level(start_level),
        .i_end_level(end_level), .i_smooth_shape(smooth_shape),
        .i_elapsed_time(elapsed_time),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_target_level(target_level), .o_current_stage(current_stage),
        .o_past_end(past_end), .o_total_time(total_time)
    );

    stage_profile_setpoint_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_command(command), .i_stage_slot(stage_slot),
        .i_stage_duration(stage_duration), .i_start_level(start_level),
        .i_end_level(end_level), .i_smooth_shape(smooth_shape),
        .i_elapsed_time(elapsed_time),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_target_level(target_level), .i_current_stage(current_stage),
        .i_past_end(past_end), .i_total_time(total_time),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("no progress for %0d cycles", STALL_LIMIT);
            $display("stage_profile_setpoint_top test failed");
            $finish;
        end
    end

    // result side: hold for a drawn number of cycles, then take one beat
    initial begin
        int n;
        @(posedge clk iff rst_n);
        forever begin
            n = receiver_idles ? $urandom_range(0, 10) : 0;
            if (long_hold) begin
                n = 400;
                long_hold = 0;
            end
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    task automatic send_beat(logic cmd, logic [2:0] slot, logic [23:0] dur,
                             logic [15:0] lo, logic [15:0] hi, logic smooth,
                             logic [31:0] t);
        int gap;
        gap = sender_idles ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        command <= cmd;
        stage_slot <= slot;
        stage_duration <= dur;
        start_level <= lo;
        end_level <= hi;
        smooth_shape <= smooth;
        elapsed_time <= t;
        in_valid <= 1'b1;
        do @(posedge clk); while (!(in_valid && !in_stall));
        if (cmd == CMD_LOAD) n_loads++;
        else n_queries++;
    endtask

    task automatic query_at(logic [31:0] t);
        send_beat(CMD_QUERY, 3'($urandom), 24'($urandom), 16'($urandom),
                  16'($urandom), 1'($urandom), t);
    endtask

    // drain, let the sequencer settle, then write the stage count
    task automatic set_stage_count(logic [3:0] cnt);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= cnt;
        @(posedge clk);
        cfg_we <= 1'b0;
        n_configs++;
    endtask

    function automatic logic [23:0] draw_duration();
        int k;
        k = $urandom_range(0, 99);
        if (k < 8) return 24'd0;
        if (k < 11) return 24'hFFFFFF;
        if (k < 18) return 24'($urandom);
        return 24'($urandom_range(1, 2000));
    endfunction

    function automatic logic [15:0] draw_level();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 16'h8000;
        if (k == 1) return 16'h7FFF;
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] draw_elapsed();
        int k;
        k = $urandom_range(0, 9);
        if (k < 4) return $urandom_range(0, 8000);
        if (k < 6) return $urandom_range(0, 30000);
        if (k < 8) return $urandom;
        if (k == 8) return 32'd0;
        return 32'hFFFFFFFF;
    endfunction

    initial begin
        logic [3:0] counts[10] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8,
                                    4'd5, 4'd2, 4'd7, 4'd12};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no stages in use
        query_at(32'd0);
        query_at(32'hFFFFFFFF);
        send_beat(CMD_LOAD, 3'd0, 24'd1000, 16'h8000, 16'h7FFF, 1'b0, '0);
        send_beat(CMD_LOAD, 3'd1, 24'd0, 16'd100, 16'd200, 1'b1, '0);
        send_beat(CMD_LOAD, 3'd2, 24'hFFFFFF, 16'h7FFF, 16'h8000, 1'b1, '0);
        send_beat(CMD_LOAD, 3'd3, 24'd500, 16'd0, 16'd1600, 1'b1, '0);
        send_beat(CMD_LOAD, 3'd4, 24'd1, 16'hFF00, 16'h0100, 1'b0, '0);
        send_beat(CMD_LOAD, 3'd5, 24'd3000, 16'd400, 16'd400, 1'b0, '0);
        send_beat(CMD_LOAD, 3'd6, 24'd0, 16'd0, 16'd0, 1'b0, '0);
        send_beat(CMD_LOAD, 3'd7, 24'd777, 16'hF000, 16'h1234, 1'b1, '0);

        set_stage_count(4'd8);
        query_at(32'd0);
        query_at(32'd999);
        query_at(32'd1000);
        query_at(32'd1001);
        query_at(32'h0100_0000);
        query_at(32'h0100_03E7);
        query_at(32'hFFFFFFFF);
        set_stage_count(4'd15);
        query_at(32'd500);
        query_at(32'hFFFFFFFF);
        set_stage_count(4'd1);
        query_at(32'd250);
        query_at(32'd1000);

        for (int ph = 0; ph < 10; ph++) begin
            set_stage_count(counts[ph]);
            sender_idles = (ph % 4) != 1;
            receiver_idles = (ph % 4) != 2;
            if (ph == 4) long_hold = 1;
            for (int i = 0; i < 200; i++) begin
                if ($urandom_range(0, 3) == 0)
                    send_beat(CMD_LOAD, 3'($urandom), draw_duration(), draw_level(),
                              draw_level(), 1'($urandom), $urandom);
                else
                    query_at(draw_elapsed());
                if (i == 100 && ph == 6) begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (pending != 0) @(posedge clk);
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        $display("covered %0d loads, %0d queries over %0d stage-count settings",
                 n_loads, n_queries, n_configs);
        $display("with random gaps, unthrottled phases and a long output hold");
        if (errors == 0)
            $display("stage_profile_setpoint_top test passed");
        else
            $display("stage_profile_setpoint_top test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/sps_pkg.sv
sv/sps_ram.sv
sv/sps_div.sv
sv/stage_profile_setpoint_top.sv
tb/stage_profile_setpoint_checker.sv
tb/stage_profile_setpoint_top_tb.sv
